FILE: sv/asr_pkg.sv
package asr_pkg;

    // Screen page layout
    localparam int unsigned PageBytes = 6912;
    localparam int unsigned AddrW     = 13;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned LineW     = 8;
    localparam int unsigned ColumnW   = 5;
    localparam int unsigned ColourW   = 4;
    localparam int unsigned Pixels    = 8;
    localparam int unsigned FrameW    = 4;

    localparam logic [AddrW-1:0] AttrBase  = 13'h1800;
    localparam logic [AddrW-1:0] PageLimit = 13'(PageBytes);

    // Attribute byte fields
    localparam int unsigned AttrFlashBit  = 7;
    localparam int unsigned AttrBrightBit = 6;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef logic [ColourW-1:0] t_colour;
    typedef t_colour [Pixels-1:0] t_colour_row;

    // Bitmap offset: interleaved thirds, pixel rows and character rows
    function automatic logic [AddrW-1:0] pix_addr(input logic [LineW-1:0] line,
                                                 input logic [ColumnW-1:0] column);
        pix_addr = {line[7:6], line[2:0], line[5:3], column};
    endfunction

    // Attribute offset: one byte per 8-line cell
    function automatic logic [AddrW-1:0] attr_addr(input logic [LineW-1:0] line,
                                                  input logic [ColumnW-1:0] column);
        attr_addr = AttrBase + {3'b000, line[7:3], column};
    endfunction

endpackage

FILE: sv/attribute_screen_cell_render_core.sv
// Attribute-screen cell renderer. The block keeps one 6912-byte screen page
// (6144 bitmap bytes, then 768 attribute bytes) in a single-ported RAM with a
// registered read. A write word stores one byte and returns nothing; writes
// beyond the page are dropped. A render word issues two reads on the one RAM
// port, bitmap then attribute, so the input side is busy through the attribute
// read. The bitmap byte is held while the attribute is read, and the colour
// word then enters the output register once that register is free. The next
// word may be taken in the cycle the colour word is formed, provided the
// output register is free or being drained. A render of line 0, column 0
// advances the frame counter and, on wrap, toggles the flash phase before the
// cell is coloured. Screen bytes must be written before they are rendered.
module attribute_screen_cell_render_core
    import asr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [AddrW-1:0]   i_byte_address,
    input  logic [ByteW-1:0]   i_byte_value,
    input  logic [LineW-1:0]   i_line,
    input  logic [ColumnW-1:0] i_column,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ColourW-1:0] o_colour_0,
    output logic [ColourW-1:0] o_colour_1,
    output logic [ColourW-1:0] o_colour_2,
    output logic [ColourW-1:0] o_colour_3,
    output logic [ColourW-1:0] o_colour_4,
    output logic [ColourW-1:0] o_colour_5,
    output logic [ColourW-1:0] o_colour_6,
    output logic [ColourW-1:0] o_colour_7
);

    typedef enum logic {
        S_IDLE,
        S_ATTR
    } t_state;

    t_state             r_state, n_state;
    logic [LineW-1:0]   r_line, n_line;
    logic [ColumnW-1:0] r_column, n_column;
    logic               r_pix_ok, n_pix_ok;
    logic               r_attr_ok, n_attr_ok;
    logic [ByteW-1:0]   r_pixel, n_pixel;
    logic               r_col_pend, n_col_pend;
    logic [FrameW-1:0]  r_frame, n_frame;
    logic               r_flash, n_flash;
    logic               r_out_valid, n_out_valid;
    t_colour_row        r_colour, n_colour;

    logic               accept;
    logic               out_free;
    logic [AddrW-1:0]   in_pix_addr;
    logic [AddrW-1:0]   cur_attr_addr;
    logic [FrameW:0]    frame_inc;
    logic               ram_en;
    logic               ram_we;
    logic [AddrW-1:0]   ram_addr;
    logic [ByteW-1:0]   ram_rdata;
    t_colour_row        shade_row;

    // Handshake: hold the input during the attribute read and while the colour stage cannot drain
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && !(r_col_pend && !out_free);
    assign accept   = i_valid && o_ready;

    assign in_pix_addr   = pix_addr(i_line, i_column);
    assign cur_attr_addr = attr_addr(r_line, r_column);
    assign frame_inc     = {1'b0, r_frame} + {{FrameW{1'b0}}, 1'b1};

    // Share the single RAM port: attribute read, else the accepted word
    always_comb begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = cur_attr_addr;
        if (r_state == S_ATTR) begin
            ram_en   = cur_attr_addr < PageLimit;
        end else if (accept) begin
            if (t_op'(i_op) == OP_WRITE) begin
                ram_en   = i_byte_address < PageLimit;
                ram_we   = 1'b1;
                ram_addr = i_byte_address;
            end else begin
                ram_en   = in_pix_addr < PageLimit;
                ram_addr = in_pix_addr;
            end
        end
    end

    asr_ram #(
        .Width (ByteW),
        .Depth (PageBytes)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_byte_value),
        .o_rdata (ram_rdata)
    );

    // Colour the cell from the held bitmap byte and the fresh attribute byte
    asr_shade u_shade (
        .i_pixel   (r_pixel),
        .i_pix_ok  (r_pix_ok),
        .i_attr    (ram_rdata),
        .i_attr_ok (r_attr_ok),
        .i_flash   (r_flash),
        .o_colour  (shade_row)
    );

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_column    = r_column;
        n_pix_ok    = r_pix_ok;
        n_attr_ok   = r_attr_ok;
        n_pixel     = r_pixel;
        n_col_pend  = r_col_pend;
        n_frame     = r_frame;
        n_flash     = r_flash;
        n_out_valid = r_out_valid;
        n_colour    = r_colour;

        // Drain the output register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        // Load the colour word once the output register is free
        if (r_col_pend && out_free) begin
            n_colour    = shade_row;
            n_out_valid = 1'b1;
            n_col_pend  = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && t_op'(i_op) == OP_RENDER) begin
                    n_line   = i_line;
                    n_column = i_column;
                    n_pix_ok = in_pix_addr < PageLimit;
                    n_state  = S_ATTR;
                    // Advance the frame count at the top-left cell
                    if (i_line == '0 && i_column == '0) begin
                        if (frame_inc[FrameW]) begin
                            n_frame = '0;
                            n_flash = !r_flash;
                        end else begin
                            n_frame = frame_inc[FrameW-1:0];
                        end
                    end
                end
            end
            S_ATTR: begin
                n_pixel    = ram_rdata;
                n_attr_ok  = cur_attr_addr < PageLimit;
                n_col_pend = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col_pend  <= 1'b0;
            r_frame     <= '0;
            r_flash     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col_pend  <= n_col_pend;
            r_frame     <= n_frame;
            r_flash     <= n_flash;
            r_out_valid <= n_out_valid;
        end
        r_line    <= n_line;
        r_column  <= n_column;
        r_pix_ok  <= n_pix_ok;
        r_attr_ok <= n_attr_ok;
        r_pixel   <= n_pixel;
        r_colour  <= n_colour;
    end

    assign o_valid    = r_out_valid;
    assign o_colour_0 = r_colour[0];
    assign o_colour_1 = r_colour[1];
    assign o_colour_2 = r_colour[2];
    assign o_colour_3 = r_colour[3];
    assign o_colour_4 = r_colour[4];
    assign o_colour_5 = r_colour[5];
    assign o_colour_6 = r_colour[6];
    assign o_colour_7 = r_colour[7];

    // A render word always moves on to the attribute read
    a_render_to_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_RENDER |=> r_state == S_ATTR)
        else $error("render word did not start the attribute read");

    // The colour stage is armed only by an attribute read
    a_pend_from_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_col_pend) |-> $past(r_state == S_ATTR))
        else $error("colour stage armed without an attribute read");

    // Never accept while a colour word is stuck behind a full output
    a_no_accept_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_pend && r_out_valid && !i_ready |-> !o_ready)
        else $error("input accepted while colour stage blocked");

    // A result appears only from the colour stage
    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_col_pend |=> !$rose(r_out_valid))
        else $error("result word without a pending render");

    // The RAM port is never asked for two accesses at once
    a_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ATTR |-> !o_ready && !ram_we)
        else $error("RAM port conflict during attribute read");

endmodule

FILE: sv/asr_ram.sv
module asr_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 6912,
    localparam int unsigned AW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [Width-1:0] i_wdata,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write, or read into the output register; hold the last read otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/asr_shade.sv
module asr_shade
    import asr_pkg::*;
(
    input  logic [ByteW-1:0] i_pixel,
    input  logic             i_pix_ok,
    input  logic [ByteW-1:0] i_attr,
    input  logic             i_attr_ok,
    input  logic             i_flash,
    output t_colour_row      o_colour
);

    logic [ByteW-1:0] pixel;
    logic [ByteW-1:0] attr;
    logic [ByteW-1:0] shown;
    t_colour          ink;
    t_colour          paper;

    // Drop bytes that lie beyond the page
    assign pixel = i_pix_ok  ? i_pixel : '0;
    assign attr  = i_attr_ok ? i_attr  : '0;

    // Invert the pixel word on flashing cells in the on phase
    assign shown = (attr[AttrFlashBit] && i_flash) ? ~pixel : pixel;

    assign ink   = {attr[AttrBrightBit], attr[2:0]};
    assign paper = attr[6:3];

    // Pick ink or paper per pixel, leftmost from the top bit
    always_comb begin
        for (int k = 0; k < Pixels; k++) begin
            o_colour[k] = shown[Pixels-1-k] ? ink : paper;
        end
    end

endmodule
